FILE: hw/rtl/tes_pkg.sv
// shared types, constants and helpers of the tick event scheduler
`default_nettype none
package tes_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int COND_W = 16;

    typedef enum logic [1:0] {
        FUNC_ONESHOT  = 2'd0,
        FUNC_PERIODIC = 2'd1,
        FUNC_UNSCHED  = 2'd2,
        FUNC_TICK     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_SCHED = 2'd0,
        KIND_FIRE  = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [31:0]        ident;
        logic signed [31:0] remaining;
        logic [15:0]        period;
        logic               periodic;
    } slot_entry_t;

    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        slot_entry_t        wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               status;
        logic [31:0]        event_id_res;
        logic [3:0]         slot_index;
        logic signed [31:0] next_due;
        logic [7:0]         elapsed;
        logic               last;
    } res_t;

    // condition bit of a slot; slots past the mask width count as gated
    function automatic logic cond_bit(input logic [COND_W-1:0] mask,
                                      input logic [IDX_W-1:0] idx);
        logic [63:0] wide;
        wide = 64'(mask);
        return wide[idx];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tes_channels.sv
// request and result channel interfaces
`default_nettype none
interface tes_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] timeout_ticks;
    logic [31:0] event_id;
    logic [7:0]  tick_count;
    logic [15:0] condition_mask;

    modport source (output valid, func, timeout_ticks, event_id, tick_count,
                    condition_mask, input ready);
    modport sink (input valid, func, timeout_ticks, event_id, tick_count,
                  condition_mask, output ready);
endinterface

interface tes_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic               status;
    logic [31:0]        event_id_res;
    logic [3:0]         slot_index;
    logic signed [31:0] next_due;
    logic [7:0]         elapsed;
    logic               last;

    modport source (output valid, kind, status, event_id_res, slot_index, next_due,
                    elapsed, last, input ready);
    modport sink (input valid, kind, status, event_id_res, slot_index, next_due,
                  elapsed, last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tes_slot_store.sv
// slot table memory, one read and one write port, registered read
`default_nettype none
module tes_slot_store
(
    input  wire logic              clk,
    input  wire tes_pkg::mem_req_t mem_req,
    output tes_pkg::slot_entry_t   rd_data
);

    tes_pkg::slot_entry_t mem [tes_pkg::SLOTS];

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data <= mem[mem_req.rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tes_sequencer.sv
// request sequencer: allocation, unschedule scan, countdown, firing, summary
`default_nettype none
module tes_sequencer
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    tes_req_if.sink                   req,
    output tes_pkg::mem_req_t         mem_req,
    input  wire tes_pkg::slot_entry_t rd_data,
    input  wire logic                 out_free,
    output logic                      emit_vld,
    output tes_pkg::res_t             emit_res
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SCHED = 8'b0000_0010,
        ST_UNSCH = 8'b0000_0100,
        ST_CDOWN = 8'b0000_1000,
        ST_FSCAN = 8'b0001_0000,
        ST_FIRE  = 8'b0010_0000,
        ST_SUMM  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    localparam logic [tes_pkg::CNT_W-1:0] SCAN_END = tes_pkg::CNT_W'(tes_pkg::SLOTS);

    state_t state_reg, state_next;
    logic [tes_pkg::SLOTS-1:0] valid_reg, valid_next;
    logic [tes_pkg::SLOTS-1:0] mark_reg, mark_next;
    logic [tes_pkg::SLOTS-1:0] due_reg, due_next;
    logic [31:0] next_ident_reg, next_ident_next;
    logic [tes_pkg::CNT_W-1:0] scan_addr_reg, scan_addr_next;
    logic proc_vld_reg, proc_vld_next;
    logic [tes_pkg::IDX_W-1:0] proc_idx_reg, proc_idx_next;

    logic [1:0]  func_reg, func_next;
    logic [15:0] timeout_reg, timeout_next;
    logic [31:0] eid_reg, eid_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] mask_reg, mask_next;

    logic best_found_reg, best_found_next;
    logic [31:0] best_key_reg, best_key_next;
    logic [tes_pkg::IDX_W-1:0] best_idx_reg, best_idx_next;
    tes_pkg::slot_entry_t best_entry_reg, best_entry_next;
    logic min_found_reg, min_found_next;
    logic signed [31:0] min_reg, min_next;

    logic in_scan;
    logic scan_end;
    logic free_found;
    logic [tes_pkg::IDX_W-1:0] free_idx;
    logic signed [32:0] diff;
    logic signed [31:0] sat;
    logic [31:0] key;
    logic cond;
    tes_pkg::slot_entry_t upd;

    assign req.ready = (state_reg == ST_IDLE);
    assign in_scan = (state_reg == ST_UNSCH) || (state_reg == ST_CDOWN)
                     || (state_reg == ST_FSCAN) || (state_reg == ST_SUMM);
    assign scan_end = (scan_addr_reg == SCAN_END) && !proc_vld_reg;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = tes_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = tes_pkg::IDX_W'(i);
            end
        end
    end

    // saturating countdown of the slot just read
    always_comb
    begin
        diff = {rd_data.remaining[31], rd_data.remaining} - $signed({25'd0, count_reg});
        if (diff[32] != diff[31])
        begin
            sat = 32'sh8000_0000;
        end
        else
        begin
            sat = diff[31:0];
        end
        key  = rd_data.ident - next_ident_reg;
        cond = tes_pkg::cond_bit(mask_reg, proc_idx_reg);
        upd  = rd_data;
        upd.remaining = sat;
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        mark_next       = mark_reg;
        due_next        = due_reg;
        next_ident_next = next_ident_reg;
        scan_addr_next  = scan_addr_reg;
        proc_vld_next   = 1'b0;
        proc_idx_next   = proc_idx_reg;
        func_next       = func_reg;
        timeout_next    = timeout_reg;
        eid_next        = eid_reg;
        count_next      = count_reg;
        mask_next       = mask_reg;
        best_found_next = best_found_reg;
        best_key_next   = best_key_reg;
        best_idx_next   = best_idx_reg;
        best_entry_next = best_entry_reg;
        min_found_next  = min_found_reg;
        min_next        = min_reg;
        mem_req         = '0;
        emit_vld        = 1'b0;
        emit_res        = '0;

        if (in_scan && (scan_addr_reg != SCAN_END))
        begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = scan_addr_reg[tes_pkg::IDX_W-1:0];
            scan_addr_next  = scan_addr_reg + 1'b1;
            proc_vld_next   = 1'b1;
            proc_idx_next   = scan_addr_reg[tes_pkg::IDX_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    func_next      = req.func;
                    timeout_next   = req.timeout_ticks;
                    eid_next       = req.event_id;
                    count_next     = req.tick_count;
                    mask_next      = req.condition_mask;
                    scan_addr_next = '0;
                    unique case (req.func) inside
                        tes_pkg::FUNC_ONESHOT, tes_pkg::FUNC_PERIODIC:
                            state_next = ST_SCHED;
                        tes_pkg::FUNC_UNSCHED:
                            state_next = ST_UNSCH;
                        default:
                        begin
                            min_found_next = 1'b0;
                            min_next       = 32'sh7fff_ffff;
                            if (req.tick_count != 8'd0)
                            begin
                                valid_next = valid_reg & ~mark_reg;
                                mark_next  = mark_reg & ~valid_reg;
                                state_next = ST_CDOWN;
                            end
                            else
                            begin
                                state_next = ST_SUMM;
                            end
                        end
                    endcase
                end
            end
            ST_SCHED:
            begin
                if (out_free)
                begin
                    emit_vld        = 1'b1;
                    emit_res.kind   = tes_pkg::KIND_SCHED;
                    emit_res.last   = 1'b1;
                    if (free_found)
                    begin
                        mem_req.wr_en              = 1'b1;
                        mem_req.wr_addr            = free_idx;
                        mem_req.wr_data.ident      = next_ident_reg;
                        mem_req.wr_data.remaining  = $signed({16'd0, timeout_reg});
                        mem_req.wr_data.period     = timeout_reg;
                        mem_req.wr_data.periodic   = (func_reg == tes_pkg::FUNC_PERIODIC);
                        valid_next[free_idx]       = 1'b1;
                        mark_next[free_idx]        = 1'b0;
                        emit_res.event_id_res      = next_ident_reg;
                        emit_res.slot_index        = 4'(free_idx);
                        next_ident_next            = next_ident_reg + 32'd1;
                    end
                    else
                    begin
                        emit_res.status = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_UNSCH:
            begin
                if (proc_vld_reg && valid_reg[proc_idx_reg] && (rd_data.ident == eid_reg))
                begin
                    mark_next[proc_idx_reg] = 1'b1;
                end
                if (scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CDOWN:
            begin
                if (proc_vld_reg)
                begin
                    due_next[proc_idx_reg] = 1'b0;
                    if (valid_reg[proc_idx_reg])
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = proc_idx_reg;
                        mem_req.wr_data = upd;
                        due_next[proc_idx_reg] = (sat <= 0) && (!rd_data.periodic || cond);
                    end
                end
                if (scan_end)
                begin
                    scan_addr_next  = '0;
                    best_found_next = 1'b0;
                    state_next      = ST_FSCAN;
                end
            end
            ST_FSCAN:
            begin
                if (proc_vld_reg && due_reg[proc_idx_reg]
                    && (!best_found_reg || (key < best_key_reg)))
                begin
                    best_found_next = 1'b1;
                    best_key_next   = key;
                    best_idx_next   = proc_idx_reg;
                    best_entry_next = rd_data;
                end
                if (scan_end)
                begin
                    scan_addr_next = '0;
                    state_next     = best_found_reg ? ST_FIRE : ST_SUMM;
                end
            end
            ST_FIRE:
            begin
                if (out_free)
                begin
                    emit_vld              = 1'b1;
                    emit_res.kind         = tes_pkg::KIND_FIRE;
                    emit_res.event_id_res = best_entry_reg.ident;
                    emit_res.slot_index   = 4'(best_idx_reg);
                    due_next[best_idx_reg] = 1'b0;
                    if (best_entry_reg.periodic)
                    begin
                        mem_req.wr_en             = 1'b1;
                        mem_req.wr_addr           = best_idx_reg;
                        mem_req.wr_data           = best_entry_reg;
                        mem_req.wr_data.remaining = $signed({16'd0, best_entry_reg.period});
                    end
                    else
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                        mark_next[best_idx_reg]  = 1'b0;
                    end
                    scan_addr_next  = '0;
                    best_found_next = 1'b0;
                    state_next      = ST_FSCAN;
                end
            end
            ST_SUMM:
            begin
                if (proc_vld_reg && valid_reg[proc_idx_reg] && (!rd_data.periodic || cond))
                begin
                    min_found_next = 1'b1;
                    if (rd_data.remaining < min_reg)
                    begin
                        min_next = rd_data.remaining;
                    end
                end
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    emit_vld         = 1'b1;
                    emit_res.kind    = tes_pkg::KIND_DONE;
                    emit_res.elapsed = count_reg;
                    emit_res.last    = 1'b1;
                    if (!min_found_reg)
                    begin
                        emit_res.next_due = -32'sd1;
                    end
                    else if (min_reg < 0)
                    begin
                        emit_res.next_due = '0;
                    end
                    else
                    begin
                        emit_res.next_due = min_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            mark_reg       <= '0;
            due_reg        <= '0;
            next_ident_reg <= '0;
            scan_addr_reg  <= '0;
            proc_vld_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            min_found_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            mark_reg       <= mark_next;
            due_reg        <= due_next;
            next_ident_reg <= next_ident_next;
            scan_addr_reg  <= scan_addr_next;
            proc_vld_reg   <= proc_vld_next;
            best_found_reg <= best_found_next;
            min_found_reg  <= min_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg   <= proc_idx_next;
        func_reg       <= func_next;
        timeout_reg    <= timeout_next;
        eid_reg        <= eid_next;
        count_reg      <= count_next;
        mask_reg       <= mask_next;
        best_key_reg   <= best_key_next;
        best_idx_reg   <= best_idx_next;
        best_entry_reg <= best_entry_next;
        min_reg        <= min_next;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tick_event_scheduler_core.sv
// top level of the tick event scheduler
//
//  channel | dir | carries
//  --------+-----+------------------------------------------------------------
//  req     | in  | func, timeout_ticks, event_id, tick_count, condition_mask
//  res     | out | kind, status, event_id_res, slot_index, next_due, elapsed,
//          |     | last
//
// every pass walks the slot memory one entry a cycle through its single
// read port; reset clears valid and remove marks at once; no clearing pass
// a result waits in the output register; a full one stalls the sequencer only
// before a result; an unschedule has none, else a new request follows its last
`default_nettype none
module tick_event_scheduler_core
(
    input  wire logic clk,
    input  wire logic rst_n,
    tes_req_if.sink   req,
    tes_res_if.source res
);

    tes_pkg::mem_req_t    mem_req;
    tes_pkg::slot_entry_t rd_data;
    tes_pkg::res_t        emit_res;
    tes_pkg::res_t        out_reg;
    logic                 emit_vld;
    logic                 out_free;
    logic                 out_vld_reg;

    // slot table: id, count, period and mode per slot
    tes_slot_store u_store
    (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // control: walks the table for unschedule and tick requests
    tes_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .mem_req  (mem_req),
        .rd_data  (rd_data),
        .out_free (out_free),
        .emit_vld (emit_vld),
        .emit_res (emit_res)
    );

    // output register, free once empty or being taken
    assign out_free = !out_vld_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (emit_vld)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_vld)
        begin
            out_reg <= emit_res;
        end
    end

    assign res.valid        = out_vld_reg;
    assign res.kind         = out_reg.kind;
    assign res.status       = out_reg.status;
    assign res.event_id_res = out_reg.event_id_res;
    assign res.slot_index   = out_reg.slot_index;
    assign res.next_due     = out_reg.next_due;
    assign res.elapsed      = out_reg.elapsed;
    assign res.last         = out_reg.last;

endmodule
`default_nettype wire
